// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// each macro expands to one labeled concurrent assertion on a clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/tcdda_pkg.sv =====
// shared types, constants and helpers of the direction dispatch arbiter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcdda_pkg;

  // default sizing
  localparam int ENTRIES_DEF     = 64;
  localparam int TIME_BITS_DEF   = 16;

  // fixed field widths on the ports
  localparam int IDX_FIELD_BITS  = 6;
  localparam int TIME_FIELD_BITS = 16;
  localparam int IN_DATA_BITS    = 24;
  localparam int OUT_DATA_BITS   = 8;

  // width for comparing a slot number against the table size
  localparam int CNT_BITS        = 9;

  // input selector codes
  localparam logic FUNC_INSERT   = 1'b0;
  localparam logic FUNC_DISPATCH = 1'b1;

  // grant history codes
  typedef enum logic [1:0] {
    HIST_EMPTY = 2'd0,
    HIST_EAST  = 2'd1,
    HIST_WEST  = 2'd2
  } hist_code_t;

  // three-deep grant history, h0 is the most recent grant
  typedef struct packed {
    hist_code_t h2;
    hist_code_t h1;
    hist_code_t h0;
  } hist_t;

  // history code of a direction
  function automatic hist_code_t dir_code(input logic east);
    return east ? HIST_EAST : HIST_WEST;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tcdda_pick.sv =====
// compare unit: decides whether a scanned slot displaces the current candidate
// depends on tcdda_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcdda_pick #(
  parameter int TIME_BITS = tcdda_pkg::TIME_BITS_DEF
) (
  input  tcdda_pkg::hist_t       hist,
  input  logic                   new_east,
  input  logic                   new_high,
  input  logic [TIME_BITS-1:0]   new_time,
  input  logic                   cand_east,
  input  logic                   cand_high,
  input  logic [TIME_BITS-1:0]   cand_time,
  output logic                   displace
);

  logic full;
  logic starve_east;
  logic starve_west;
  logic starve_new;
  logic starve_cand;

  // a direction starves when the full history never names it
  always_comb begin
    full = (hist.h0 != tcdda_pkg::HIST_EMPTY) && (hist.h1 != tcdda_pkg::HIST_EMPTY) &&
           (hist.h2 != tcdda_pkg::HIST_EMPTY);
    starve_east = full && (hist.h0 != tcdda_pkg::HIST_EAST) &&
                  (hist.h1 != tcdda_pkg::HIST_EAST) && (hist.h2 != tcdda_pkg::HIST_EAST);
    starve_west = full && (hist.h0 != tcdda_pkg::HIST_WEST) &&
                  (hist.h1 != tcdda_pkg::HIST_WEST) && (hist.h2 != tcdda_pkg::HIST_WEST);
    starve_new  = new_east  ? starve_east : starve_west;
    starve_cand = cand_east ? starve_east : starve_west;
  end

  // priority: starvation, class, ready time (same direction) or alternation
  always_comb begin
    if (starve_new != starve_cand) begin
      displace = starve_new;
    end else if (new_high != cand_high) begin
      displace = new_high;
    end else if (new_east == cand_east) begin
      displace = (new_time <= cand_time);
    end else if (hist.h0 == tcdda_pkg::HIST_EMPTY) begin
      displace = new_east;
    end else begin
      displace = (tcdda_pkg::dir_code(new_east) != hist.h0);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/two_class_direction_dispatch_arbiter.sv =====
// Two-class direction dispatch arbiter.
// Input stream s_*: s_tuser selects insert (0) or dispatch (1); s_tdata carries
// the slot, direction, class and ready time. Output stream m_*: one word per
// input word; m_tuser is the grant flag, m_tdata the granted slot and direction.
// An insert writes the slot into the table and marks it pending if the slot lies
// inside the table; its result is all zero and goes out from the finish state.
// A dispatch scans the table from the top slot down, one slot per cycle through
// the registered table read port and one shared compare unit, then grants the
// winner. After the scan come the drain, grant and finish states; the finish
// state loads the result into the output register and returns to idle for the next word.
// One item is in work at a time: s_tready is high only while the sequencer is
// idle. The result waits in an output register, so a new item is taken while
// the receiver holds m_tready low; a finished result then waits until the
// output register is free.
// Reset (rst, synchronous, active high) clears all pending marks, the grant
// history and the output valid flag. Table contents are not cleared.
// depends on tcdda_pkg and tcdda_pick
`timescale 1ns / 1ps
`default_nettype none

module two_class_direction_dispatch_arbiter #(
  parameter int ENTRIES   = tcdda_pkg::ENTRIES_DEF,
  parameter int TIME_BITS = tcdda_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [5:0] entry_index, [6] eastbound, [7] high_class, [23:8] ready_time
  input  logic [tcdda_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // [0] func
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [5:0] grant_index, [6] grant_east, [7] zero
  output logic [tcdda_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // [0] grant_valid
  output logic                                 m_tuser
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_GRANT  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;

  // input field unpacking
  logic [tcdda_pkg::IDX_FIELD_BITS-1:0]  in_index;
  logic                                  in_east;
  logic                                  in_high;
  logic [tcdda_pkg::TIME_FIELD_BITS-1:0] in_time;
  logic                                  accept;
  logic                                  in_range;
  logic [IW-1:0]                         wr_addr;

  assign in_index = s_tdata[5:0];
  assign in_east  = s_tdata[6];
  assign in_high  = s_tdata[7];
  assign in_time  = s_tdata[23:8];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_range = ({{(tcdda_pkg::CNT_BITS - tcdda_pkg::IDX_FIELD_BITS){1'b0}}, in_index}
                     < tcdda_pkg::CNT_BITS'(ENTRIES));
  assign wr_addr  = IW'(in_index);

  // slot table memory
  logic                 mem_east [ENTRIES];
  logic                 mem_high [ENTRIES];
  logic [TIME_BITS-1:0] mem_time [ENTRIES];

  logic [ENTRIES-1:0]   pending;
  logic [IW-1:0]        scan_idx;

  // read stage of the scan
  logic                 rd_valid;
  logic                 rd_pend;
  logic [IW-1:0]        rd_idx;
  logic                 rd_east;
  logic                 rd_high;
  logic [TIME_BITS-1:0] rd_time;

  // current candidate
  logic                 cand_valid;
  logic [IW-1:0]        cand_idx;
  logic                 cand_east;
  logic                 cand_high;
  logic [TIME_BITS-1:0] cand_time;

  tcdda_pkg::hist_t     history;
  logic                 displace;

  // result waiting for the output register
  logic                                  res_grant;
  logic [tcdda_pkg::IDX_FIELD_BITS-1:0]  res_idx;
  logic                                  res_east;
  logic                                  out_load;

  // table write on insert
  always_ff @(posedge clk) begin
    if (accept && (s_tuser == tcdda_pkg::FUNC_INSERT) && in_range) begin
      mem_east[wr_addr] <= in_east;
      mem_high[wr_addr] <= in_high;
      mem_time[wr_addr] <= TIME_BITS'(in_time);
    end
  end

  // registered table read during the scan
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      rd_east <= mem_east[scan_idx];
      rd_high <= mem_high[scan_idx];
      rd_time <= mem_time[scan_idx];
      rd_idx  <= scan_idx;
      rd_pend <= pending[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SCAN);
    end
  end

  // shared compare unit
  tcdda_pick #(
    .TIME_BITS (TIME_BITS)
  ) u_pick (
    .hist      (history),
    .new_east  (rd_east),
    .new_high  (rd_high),
    .new_time  (rd_time),
    .cand_east (cand_east),
    .cand_high (cand_high),
    .cand_time (cand_time),
    .displace  (displace)
  );

  // candidate update
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else if (accept) begin
      cand_valid <= 1'b0;
    end else if (rd_valid && rd_pend && (!cand_valid || displace)) begin
      cand_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid && rd_pend && (!cand_valid || displace)) begin
      cand_idx  <= rd_idx;
      cand_east <= rd_east;
      cand_high <= rd_high;
      cand_time <= rd_time;
    end
  end

  // sequencer, pending marks and grant history
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= '0;
      history <= {tcdda_pkg::HIST_EMPTY, tcdda_pkg::HIST_EMPTY, tcdda_pkg::HIST_EMPTY};
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == tcdda_pkg::FUNC_DISPATCH) begin
              state <= ST_SCAN;
            end else begin
              if (in_range) begin
                pending[wr_addr] <= 1'b1;
              end
              state <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (scan_idx == '0) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_GRANT;
        end
        ST_GRANT: begin
          if (cand_valid) begin
            pending[cand_idx] <= 1'b0;
            history.h2 <= history.h1;
            history.h1 <= history.h0;
            history.h0 <= tcdda_pkg::dir_code(cand_east);
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // scan counter, top slot down
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_idx <= IW'(ENTRIES - 1);
    end else if ((state == ST_SCAN) && (scan_idx != '0)) begin
      scan_idx <= scan_idx - 1'b1;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (accept) begin
      res_grant <= 1'b0;
      res_idx   <= '0;
      res_east  <= 1'b0;
    end else if ((state == ST_GRANT) && cand_valid) begin
      res_grant <= 1'b1;
      res_idx   <= tcdda_pkg::IDX_FIELD_BITS'(cand_idx);
      res_east  <= cand_east;
    end
  end

  // output register
  assign out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, res_east, res_idx};
      m_tuser <= res_grant;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcdda_checker.sv =====
// port-level checker for the direction dispatch arbiter, with its bind
// depends on assert_macros.svh and tcdda_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tcdda_checker #(
  parameter int ENTRIES = tcdda_pkg::ENTRIES_DEF
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic [tcdda_pkg::IN_DATA_BITS-1:0]  s_tdata,
  input wire logic                                s_tuser,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [tcdda_pkg::OUT_DATA_BITS-1:0] m_tdata,
  input wire logic                                m_tuser
);

  logic [tcdda_pkg::CNT_BITS-1:0] grant_slot;

  assign grant_slot = tcdda_pkg::CNT_BITS'(m_tdata[5:0]);

  // a word with no grant is all zero
  `ASSERT_SAME(a_nogrant_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
  // a granted slot lies inside the table
  `ASSERT_SAME(a_grant_range, clk, rst, m_tvalid && m_tuser,
    grant_slot < tcdda_pkg::CNT_BITS'(ENTRIES))
  // the sequencer is busy right after taking a word
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  // a stalled output word holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind two_class_direction_dispatch_arbiter tcdda_checker #(
  .ENTRIES (ENTRIES)
) u_tcdda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
